@@ hdl/mcjs_pkg.sv @@
package mcjs_pkg;

  localparam int MaxCoresDef   = 16;
  localparam int QueueDepthDef = 64;

  localparam logic [2:0] SchFcfs = 3'd0;
  localparam logic [2:0] SchSjf  = 3'd1;
  localparam logic [2:0] SchPsjf = 3'd2;
  localparam logic [2:0] SchPri  = 3'd3;
  localparam logic [2:0] SchPpri = 3'd4;
  localparam logic [2:0] SchRr   = 3'd5;

  localparam logic RegScheme = 1'b0;
  localparam logic RegCores  = 1'b1;

  typedef enum logic [1:0] {
    OP_NEW     = 2'd0,
    OP_FINISH  = 2'd1,
    OP_QUANTUM = 2'd2,
    OP_QUERY   = 2'd3
  } opcode_e;

  typedef struct packed {
    logic [15:0] job;
    logic [15:0] prio;
    logic [31:0] arrival;
    logic [31:0] left;
    logic [31:0] needed;
    logic        started;
    logic [31:0] start_time;
  } job_rec_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_INS_READ,
    S_INS_CMP,
    S_FIN,
    S_HEAD_USE,
    S_Q_CMP,
    S_EMIT
  } state_e;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_PLACE_NEW,
    DP_OVF,
    DP_SCAN_INIT,
    DP_SCAN_STEP,
    DP_PREEMPT,
    DP_INS_NEW,
    DP_INS_READ,
    DP_INS_CMP,
    DP_FINISH,
    DP_HEAD_READ,
    DP_PUT_HEAD,
    DP_KEEP,
    DP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   requeue;
  } dp_cmd_t;

  typedef struct packed {
    opcode_e op;
    logic    core_ok;
    logic    core_busy;
    logic    has_idle;
    logic    q_full;
    logic    q_empty;
    logic    preemptive;
    logic    scan_done;
    logic    beat;
    logic    pos_zero;
    logic    ins_shift;
    logic    keep;
    logic    out_free;
  } dp_stat_t;

  // strict: a ranks ahead of b
  function automatic logic rank_ahead(job_rec_t a, job_rec_t b, logic [2:0] sch);
    logic ahead;
    ahead = 1'b0;
    case (sch) inside
      SchSjf, SchPsjf: begin
        if (a.left != b.left) ahead = a.left < b.left;
        else ahead = a.arrival < b.arrival;
      end
      SchPri, SchPpri: begin
        if (a.prio != b.prio) ahead = a.prio < b.prio;
        else ahead = a.arrival < b.arrival;
      end
      SchRr: ahead = 1'b0;
      default: ahead = a.arrival < b.arrival;
    endcase
    return ahead;
  endfunction

endpackage

@@ hdl/mcjs_ctrl.sv @@
module mcjs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mcjs_pkg::dp_stat_t stat_i,
  output mcjs_pkg::dp_cmd_t  cmd_o
);
  import mcjs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d       = state_q;
    cmd_o.op      = DP_NONE;
    cmd_o.requeue = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = DP_LOAD;
          state_d  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_EMIT;
        unique case (stat_i.op)
          OP_NEW: begin
            if (stat_i.has_idle) begin
              cmd_o.op = DP_PLACE_NEW;
            end else if (stat_i.q_full) begin
              cmd_o.op = DP_OVF;
            end else if (stat_i.preemptive) begin
              cmd_o.op = DP_SCAN_INIT;
              state_d  = S_SCAN;
            end else begin
              cmd_o.op = DP_INS_NEW;
              state_d  = S_INS_READ;
            end
          end
          OP_FINISH: begin
            if (stat_i.core_ok && stat_i.core_busy) begin
              cmd_o.op = DP_FINISH;
              state_d  = S_FIN;
            end
          end
          OP_QUANTUM: begin
            if (stat_i.core_ok && !stat_i.q_empty) begin
              cmd_o.op = DP_HEAD_READ;
              state_d  = stat_i.core_busy ? S_Q_CMP : S_HEAD_USE;
            end else if (stat_i.core_ok && stat_i.core_busy) begin
              cmd_o.op = DP_KEEP;
            end
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        if (!stat_i.scan_done) begin
          cmd_o.op = DP_SCAN_STEP;
        end else begin
          cmd_o.op = stat_i.beat ? DP_PREEMPT : DP_INS_NEW;
          state_d  = S_INS_READ;
        end
      end
      S_INS_READ: begin
        cmd_o.op = DP_INS_READ;
        state_d  = stat_i.pos_zero ? S_EMIT : S_INS_CMP;
      end
      S_INS_CMP: begin
        cmd_o.op = DP_INS_CMP;
        state_d  = stat_i.ins_shift ? S_INS_READ : S_EMIT;
      end
      S_FIN: begin
        if (stat_i.q_empty) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.op = DP_HEAD_READ;
          state_d  = S_HEAD_USE;
        end
      end
      S_HEAD_USE: begin
        cmd_o.op = DP_PUT_HEAD;
        state_d  = S_EMIT;
      end
      S_Q_CMP: begin
        if (stat_i.keep) begin
          cmd_o.op = DP_KEEP;
          state_d  = S_EMIT;
        end else begin
          cmd_o.op      = DP_PUT_HEAD;
          cmd_o.requeue = 1'b1;
          state_d       = S_INS_READ;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.op = DP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

@@ hdl/mcjs_dpath.sv @@
module mcjs_dpath #(
  parameter int MAX_CORES   = mcjs_pkg::MaxCoresDef,
  parameter int QUEUE_DEPTH = mcjs_pkg::QueueDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mcjs_pkg::dp_cmd_t  cmd_i,
  output mcjs_pkg::dp_stat_t stat_o,
  input  logic [2:0]         scheme_i,
  input  logic [4:0]         cores_i,
  input  logic [1:0]         opcode_i,
  input  logic [15:0]        job_id_i,
  input  logic [3:0]         core_index_i,
  input  logic [31:0]        event_time_i,
  input  logic [31:0]        run_time_i,
  input  logic [15:0]        job_priority_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic               scheduled_o,
  output logic [3:0]         placed_core_o,
  output logic [15:0]        placed_job_o,
  output logic               queue_overflow_o,
  output logic [63:0]        wait_total_o,
  output logic [63:0]        turnaround_total_o,
  output logic [63:0]        response_total_o,
  output logic [15:0]        jobs_done_o
);
  import mcjs_pkg::*;

  localparam int CIW = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
  localparam int NW  = $clog2(MAX_CORES + 1);
  localparam int QW  = $clog2(QUEUE_DEPTH);
  localparam int CNW = $clog2(QUEUE_DEPTH + 1);

  opcode_e     op_q;
  logic [15:0] jid_q;
  logic [3:0]  core_q;
  logic [31:0] now_q;
  logic [31:0] run_q;
  logic [15:0] prio_q;

  logic [MAX_CORES-1:0] busy_q;
  job_rec_t             slot_q [MAX_CORES];
  logic [31:0]          last_q;
  logic [63:0]          sum_wait_q, sum_ta_q, sum_rsp_q;
  logic [15:0]          done_q;

  logic [QW-1:0]  head_q;
  logic [CNW-1:0] count_q;
  logic [CNW-1:0] pos_q;
  job_rec_t       ins_q;
  logic [NW-1:0]  scan_i_q;
  logic [CIW-1:0] vict_q;
  job_rec_t       worst_q;

  logic        res_sched_q, res_ovf_q;
  logic [3:0]  res_core_q;
  logic [15:0] res_job_q;

  logic        out_valid_q, out_sched_q, out_ovf_q;
  logic [3:0]  out_core_q;
  logic [15:0] out_job_q;
  logic [63:0] out_wait_q, out_ta_q, out_rsp_q;
  logic [15:0] out_done_q;

  job_rec_t       mem_q [QUEUE_DEPTH];
  job_rec_t       rdata_q;
  logic           mem_we;
  logic [QW-1:0]  mem_waddr, mem_raddr;
  job_rec_t       mem_wdata;

  logic [NW-1:0]  n_act;
  logic           core_ok, has_idle;
  logic [CIW-1:0] core_sel, idle_idx;
  job_rec_t       cur, scan_rec, nj_run, nj_wait, hrec, vrec;
  logic [31:0]    elapsed;
  logic [31:0]    ta, wt, rs;
  logic           ins_shift;
  logic [QW-1:0]  head_next;

  function automatic logic [QW-1:0] phys(logic [QW-1:0] h, logic [CNW-1:0] l);
    logic [QW:0] s;
    s = (QW+1)'(h) + (QW+1)'(l);
    if (32'(s) >= QUEUE_DEPTH) s = s - (QW+1)'(QUEUE_DEPTH);
    return QW'(s);
  endfunction

  always_comb begin
    if (cores_i == 5'd0) n_act = NW'(1);
    else if (32'(cores_i) > MAX_CORES) n_act = NW'(MAX_CORES);
    else n_act = NW'(cores_i);
  end

  assign core_ok  = 32'(core_q) < 32'(n_act);
  assign core_sel = CIW'(core_q);
  assign cur      = slot_q[core_sel];
  assign scan_rec = slot_q[CIW'(scan_i_q)];

  always_comb begin
    has_idle = 1'b0;
    idle_idx = '0;
    for (int i = MAX_CORES - 1; i >= 0; i--) begin
      if (i < int'(n_act) && !busy_q[i]) begin
        has_idle = 1'b1;
        idle_idx = CIW'(i);
      end
    end
  end

  always_comb begin
    nj_run.job        = jid_q;
    nj_run.prio       = prio_q;
    nj_run.arrival    = now_q;
    nj_run.left       = run_q;
    nj_run.needed     = run_q;
    nj_run.started    = 1'b1;
    nj_run.start_time = now_q;
    nj_wait            = nj_run;
    nj_wait.started    = 1'b0;
    nj_wait.start_time = '0;
    hrec = rdata_q;
    if (!rdata_q.started) begin
      hrec.started    = 1'b1;
      hrec.start_time = now_q;
    end
    vrec = worst_q;
    if (worst_q.started && worst_q.start_time == now_q) begin
      vrec.started    = 1'b0;
      vrec.start_time = '0;
    end
  end

  assign elapsed = (event_time_i >= last_q) ? event_time_i - last_q : 32'd0;

  always_comb begin
    ta = (now_q >= cur.arrival) ? now_q - cur.arrival : 32'd0;
    wt = (ta >= cur.needed) ? ta - cur.needed : 32'd0;
    rs = (cur.start_time >= cur.arrival) ? cur.start_time - cur.arrival : 32'd0;
  end

  assign ins_shift = rank_ahead(ins_q, rdata_q, scheme_i);
  assign head_next = (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + QW'(1);

  always_comb begin
    stat_o.op         = op_q;
    stat_o.core_ok    = core_ok;
    stat_o.core_busy  = busy_q[core_sel];
    stat_o.has_idle   = has_idle;
    stat_o.q_full     = 32'(count_q) >= QUEUE_DEPTH;
    stat_o.q_empty    = (count_q == '0);
    stat_o.preemptive = (scheme_i == SchPsjf) || (scheme_i == SchPpri);
    stat_o.scan_done  = 32'(scan_i_q) >= 32'(n_act);
    stat_o.beat       = rank_ahead(nj_run, worst_q, scheme_i);
    stat_o.pos_zero   = (pos_q == '0);
    stat_o.ins_shift  = ins_shift;
    stat_o.keep       = rank_ahead(cur, rdata_q, scheme_i);
    stat_o.out_free   = !out_valid_q || !out_stall_i;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = phys(head_q, pos_q);
    mem_wdata = ins_q;
    mem_raddr = head_q;
    if (cmd_i.op == DP_INS_READ) begin
      mem_raddr = phys(head_q, pos_q - CNW'(1));
      mem_we    = (pos_q == '0);
    end else if (cmd_i.op == DP_INS_CMP) begin
      mem_we = 1'b1;
      if (ins_shift) mem_wdata = rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    rdata_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= '0;
      last_q      <= '0;
      sum_wait_q  <= '0;
      sum_ta_q    <= '0;
      sum_rsp_q   <= '0;
      done_q      <= '0;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == DP_EMIT) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      unique case (cmd_i.op)
        DP_LOAD: begin
          if (opcode_i != OP_QUERY) last_q <= event_time_i;
        end
        DP_PLACE_NEW: busy_q[idle_idx] <= 1'b1;
        DP_INS_READ: begin
          if (pos_q == '0) count_q <= count_q + CNW'(1);
        end
        DP_INS_CMP: begin
          if (!ins_shift) count_q <= count_q + CNW'(1);
        end
        DP_FINISH: begin
          sum_wait_q       <= sum_wait_q + 64'(wt);
          sum_ta_q         <= sum_ta_q + 64'(ta);
          sum_rsp_q        <= sum_rsp_q + 64'(rs);
          done_q           <= done_q + 16'd1;
          busy_q[core_sel] <= 1'b0;
        end
        DP_PUT_HEAD: begin
          busy_q[core_sel] <= 1'b1;
          head_q           <= head_next;
          count_q          <= count_q - CNW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      DP_LOAD: begin
        op_q        <= opcode_e'(opcode_i);
        jid_q       <= job_id_i;
        core_q      <= core_index_i;
        now_q       <= event_time_i;
        run_q       <= run_time_i;
        prio_q      <= job_priority_i;
        res_sched_q <= 1'b0;
        res_ovf_q   <= 1'b0;
        res_core_q  <= '0;
        res_job_q   <= '0;
        if (opcode_i != OP_QUERY) begin
          for (int i = 0; i < MAX_CORES; i++) begin
            if (busy_q[i]) begin
              slot_q[i].left <= (slot_q[i].left > elapsed) ? slot_q[i].left - elapsed : 32'd0;
            end
          end
        end
      end
      DP_PLACE_NEW: begin
        slot_q[idle_idx] <= nj_run;
        res_sched_q      <= 1'b1;
        res_core_q       <= 4'(idle_idx);
        res_job_q        <= jid_q;
      end
      DP_OVF: res_ovf_q <= 1'b1;
      DP_SCAN_INIT: begin
        worst_q  <= slot_q[0];
        vict_q   <= '0;
        scan_i_q <= NW'(1);
      end
      DP_SCAN_STEP: begin
        if (rank_ahead(worst_q, scan_rec, scheme_i)) begin
          worst_q <= scan_rec;
          vict_q  <= CIW'(scan_i_q);
        end
        scan_i_q <= scan_i_q + NW'(1);
      end
      DP_PREEMPT: begin
        ins_q          <= vrec;
        pos_q          <= count_q;
        slot_q[vict_q] <= nj_run;
        res_sched_q    <= 1'b1;
        res_core_q     <= 4'(vict_q);
        res_job_q      <= jid_q;
      end
      DP_INS_NEW: begin
        ins_q <= nj_wait;
        pos_q <= count_q;
      end
      DP_INS_CMP: begin
        if (ins_shift) pos_q <= pos_q - CNW'(1);
      end
      DP_PUT_HEAD: begin
        slot_q[core_sel] <= hrec;
        res_sched_q      <= 1'b1;
        res_core_q       <= core_q;
        res_job_q        <= hrec.job;
        if (cmd_i.requeue) begin
          ins_q <= cur;
          pos_q <= count_q - CNW'(1);
        end
      end
      DP_KEEP: begin
        res_sched_q <= 1'b1;
        res_core_q  <= core_q;
        res_job_q   <= cur.job;
      end
      DP_EMIT: begin
        out_sched_q <= res_sched_q;
        out_core_q  <= res_core_q;
        out_job_q   <= res_job_q;
        out_ovf_q   <= res_ovf_q;
        out_wait_q  <= sum_wait_q;
        out_ta_q    <= sum_ta_q;
        out_rsp_q   <= sum_rsp_q;
        out_done_q  <= done_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o        = out_valid_q;
  assign scheduled_o        = out_sched_q;
  assign placed_core_o      = out_core_q;
  assign placed_job_o       = out_job_q;
  assign queue_overflow_o   = out_ovf_q;
  assign wait_total_o       = out_wait_q;
  assign turnaround_total_o = out_ta_q;
  assign response_total_o   = out_rsp_q;
  assign jobs_done_o        = out_done_q;

endmodule

@@ hdl/multi_core_job_scheduler_unit.sv @@
// channel   | valid       | stall       | word
// ----------+-------------+-------------+---------------------------------------------
// event in  | in_valid_i  | in_stall_o  | opcode, job_id, core_index, time, run, prio
// result    | out_valid_o | out_stall_i | scheduled, core, job, overflow, sums, count
// config    | psel/penable| pready = 1  | scheme @ 0x0, cores_in_use @ 0x4
//
// One event at a time: a query or a direct placement passes the decide and emit states
// to the result register. A queue insertion walks the ready-queue memory one entry at a
// time, read then compare (registered read port); preemption adds a scan of cores_in_use.
// Reset clears core busy bits, queue count, time and sums; no clearing pass is needed.
// A new event is taken while the previous word waits on a stalled output.
module multi_core_job_scheduler_unit #(
  parameter int MAX_CORES   = mcjs_pkg::MaxCoresDef,
  parameter int QUEUE_DEPTH = mcjs_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] job_id_i,
  input  logic [3:0]  core_index_i,
  input  logic [31:0] event_time_i,
  input  logic [31:0] run_time_i,
  input  logic [15:0] job_priority_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        scheduled_o,
  output logic [3:0]  placed_core_o,
  output logic [15:0] placed_job_o,
  output logic        queue_overflow_o,
  output logic [63:0] wait_total_o,
  output logic [63:0] turnaround_total_o,
  output logic [63:0] response_total_o,
  output logic [15:0] jobs_done_o
);
  import mcjs_pkg::*;

  logic [2:0] scheme_q;
  logic [4:0] cores_q;
  logic       cfg_we;
  dp_cmd_t    cmd;
  dp_stat_t   stat;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scheme_q <= SchFcfs;
      cores_q  <= 5'd1;
    end else if (cfg_we) begin
      unique case (paddr[2])
        RegScheme: scheme_q <= pwdata[2:0];
        RegCores:  cores_q  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegScheme: prdata = 32'(scheme_q);
      RegCores:  prdata = 32'(cores_q);
      default:   prdata = '0;
    endcase
  end

  mcjs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mcjs_dpath #(
    .MAX_CORES   (MAX_CORES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .scheme_i           (scheme_q),
    .cores_i            (cores_q),
    .opcode_i           (opcode_i),
    .job_id_i           (job_id_i),
    .core_index_i       (core_index_i),
    .event_time_i       (event_time_i),
    .run_time_i         (run_time_i),
    .job_priority_i     (job_priority_i),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .scheduled_o        (scheduled_o),
    .placed_core_o      (placed_core_o),
    .placed_job_o       (placed_job_o),
    .queue_overflow_o   (queue_overflow_o),
    .wait_total_o       (wait_total_o),
    .turnaround_total_o (turnaround_total_o),
    .response_total_o   (response_total_o),
    .jobs_done_o        (jobs_done_o)
  );

endmodule

@@ hdl/mcjs_checker.sv @@
module mcjs_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pready,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        scheduled_o,
  input logic [3:0]  placed_core_o,
  input logic [15:0] placed_job_o,
  input logic        queue_overflow_o,
  input logic [15:0] jobs_done_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(placed_job_o)
      && $stable(scheduled_o) && $stable(jobs_done_o))
    else $error("stalled result word changed");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !scheduled_o |-> placed_core_o == 4'd0 && placed_job_o == 16'd0)
    else $error("placement fields set without a placement");

  a_ovf_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && queue_overflow_o |-> !scheduled_o)
    else $error("overflow reported together with a placement");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second event taken while one is in work");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("config port not ready");

endmodule

bind multi_core_job_scheduler_unit mcjs_props u_chk (.*);

@@ tb/mcjs_checker.sv @@
`timescale 1ns / 1ps

module mcjs_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] job_id_i,
  input  logic [3:0]  core_index_i,
  input  logic [31:0] event_time_i,
  input  logic [31:0] run_time_i,
  input  logic [15:0] job_priority_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic        scheduled_o,
  input  logic [3:0]  placed_core_o,
  input  logic [15:0] placed_job_o,
  input  logic        queue_overflow_o,
  input  logic [63:0] wait_total_o,
  input  logic [63:0] turnaround_total_o,
  input  logic [63:0] response_total_o,
  input  logic [15:0] jobs_done_o,
  output int          fails,
  output int          pending
);
  import mcjs_pkg::*;

  typedef struct {
    logic [15:0] job;
    logic [15:0] prio;
    logic [31:0] arrival;
    logic [31:0] left;
    logic [31:0] needed;
    logic [32:0] start;
  } job_t;

  typedef struct {
    logic        sched;
    logic [3:0]  core;
    logic [15:0] job;
    logic        ovf;
    logic [63:0] wsum;
    logic [63:0] tsum;
    logic [63:0] rsum;
    logic [15:0] done;
  } sched_word_t;

  logic [2:0]  sch;
  logic [4:0]  cores;
  logic        busy [16];
  job_t        slot [16];
  job_t        ready_q [$];
  logic [31:0] last_t;
  logic [63:0] wait_sum, turn_sum, resp_sum;
  logic [15:0] done_cnt;
  sched_word_t sched_q [$];

  function automatic int order_of(job_t a, job_t b);
    if (sch == SchRr) return 0;
    if (sch == SchSjf || sch == SchPsjf) begin
      if (a.left != b.left) return (a.left < b.left) ? -1 : 1;
    end else if (sch == SchPri || sch == SchPpri) begin
      if (a.prio != b.prio) return (a.prio < b.prio) ? -1 : 1;
    end
    if (a.arrival == b.arrival) return 0;
    return (a.arrival < b.arrival) ? -1 : 1;
  endfunction

  function automatic void enqueue_ranked(job_t j);
    int pos;
    pos = ready_q.size();
    while (pos > 0 && order_of(j, ready_q[pos-1]) < 0) pos--;
    ready_q.insert(pos, j);
  endfunction

  function automatic void start_on(int c, job_t j, logic [31:0] now);
    if (!j.start[32]) j.start = {1'b1, now};
    slot[c] = j;
    busy[c] = 1'b1;
  endfunction

  function automatic void schedule_event();
    sched_word_t r;
    job_t nj, cur, h;
    int n, v;
    logic [31:0] now, el;
    logic [63:0] ta, wt, rs;
    logic placed;
    opcode_e op;
    op = opcode_e'(opcode_i);
    now = event_time_i;
    n = (cores == 0) ? 1 : ((cores > 16) ? 16 : cores);
    r = '{default: '0};
    placed = 1'b0;
    if (op != OP_QUERY) begin
      el = (now >= last_t) ? now - last_t : 32'd0;
      for (int i = 0; i < 16; i++)
        if (busy[i]) slot[i].left = (slot[i].left > el) ? slot[i].left - el : 32'd0;
      last_t = now;
    end
    case (op)
      OP_NEW: begin
        nj = '{job: job_id_i, prio: job_priority_i, arrival: now, left: run_time_i,
               needed: run_time_i, start: '0};
        for (int i = 0; i < n; i++) begin
          if (!placed && !busy[i]) begin
            start_on(i, nj, now);
            r.sched = 1'b1; r.core = 4'(i); r.job = job_id_i; placed = 1'b1;
          end
        end
        if (!placed) begin
          if (ready_q.size() >= QueueDepthDef) begin
            r.ovf = 1'b1;
          end else begin
            if (sch == SchPsjf || sch == SchPpri) begin
              v = 0;
              for (int i = 1; i < n; i++) if (order_of(slot[i], slot[v]) > 0) v = i;
              if (order_of(nj, slot[v]) < 0) begin
                cur = slot[v];
                if (cur.start[32] && cur.start[31:0] == now) cur.start = '0;
                enqueue_ranked(cur);
                start_on(v, nj, now);
                r.sched = 1'b1; r.core = 4'(v); r.job = job_id_i; placed = 1'b1;
              end
            end
            if (!placed) enqueue_ranked(nj);
          end
        end
      end
      OP_FINISH: begin
        if (core_index_i < n && busy[core_index_i]) begin
          cur = slot[core_index_i];
          ta = (now >= cur.arrival) ? 64'(now - cur.arrival) : 64'd0;
          wt = (ta >= cur.needed) ? ta - cur.needed : 64'd0;
          rs = (cur.start[31:0] >= cur.arrival) ? 64'(cur.start[31:0] - cur.arrival) : 64'd0;
          wait_sum += wt;
          turn_sum += ta;
          resp_sum += rs;
          done_cnt++;
          busy[core_index_i] = 1'b0;
          if (ready_q.size() > 0) begin
            h = ready_q.pop_front();
            start_on(core_index_i, h, now);
            r.sched = 1'b1; r.core = core_index_i; r.job = h.job;
          end
        end
      end
      OP_QUANTUM: begin
        if (core_index_i < n) begin
          if (!busy[core_index_i]) begin
            if (ready_q.size() > 0) begin
              h = ready_q.pop_front();
              start_on(core_index_i, h, now);
              r.sched = 1'b1; r.core = core_index_i; r.job = h.job;
            end
          end else begin
            cur = slot[core_index_i];
            r.sched = 1'b1; r.core = core_index_i;
            if (ready_q.size() == 0 || order_of(cur, ready_q[0]) < 0) begin
              r.job = cur.job;
            end else begin
              h = ready_q.pop_front();
              enqueue_ranked(cur);
              start_on(core_index_i, h, now);
              r.job = h.job;
            end
          end
        end
      end
      default: ;
    endcase
    r.wsum = wait_sum;
    r.tsum = turn_sum;
    r.rsum = resp_sum;
    r.done = done_cnt;
    sched_q.push_back(r);
  endfunction

  function automatic void check_field(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, a);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sched_word_t e;
    if (!rst_ni) begin
      sch = SchFcfs;
      cores = 5'd1;
      for (int i = 0; i < 16; i++) busy[i] = 1'b0;
      ready_q.delete();
      sched_q.delete();
      last_t = '0;
      wait_sum = '0;
      turn_sum = '0;
      resp_sum = '0;
      done_cnt = '0;
      fails = 0;
      pending = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == RegCores) cores = pwdata[4:0];
        else sch = pwdata[2:0];
      end
      if (in_valid_i && !in_stall_o) schedule_event();
      if (out_valid_o && !out_stall_i) begin
        if (sched_q.size() == 0) begin
          $display("%0t: result word with none expected, job %0h", $time, placed_job_o);
          fails++;
        end else begin
          e = sched_q.pop_front();
          check_field("scheduled", 64'(e.sched), 64'(scheduled_o));
          check_field("placed_core", 64'(e.core), 64'(placed_core_o));
          check_field("placed_job", 64'(e.job), 64'(placed_job_o));
          check_field("queue_overflow", 64'(e.ovf), 64'(queue_overflow_o));
          check_field("wait_total", e.wsum, wait_total_o);
          check_field("turnaround_total", e.tsum, turnaround_total_o);
          check_field("response_total", e.rsum, response_total_o);
          check_field("jobs_done", 64'(e.done), 64'(jobs_done_o));
        end
      end
      pending = sched_q.size();
    end
  end

endmodule

@@ tb/multi_core_job_scheduler_unit_test.sv @@
`timescale 1ns / 1ps

module multi_core_job_scheduler_unit_test;
  import mcjs_pkg::*;

  localparam int CycleLimit = 2000000;
  localparam int ItemTarget = 1350;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        in_valid_i, in_stall_o;
  logic [1:0]  opcode_i;
  logic [15:0] job_id_i;
  logic [3:0]  core_index_i;
  logic [31:0] event_time_i, run_time_i;
  logic [15:0] job_priority_i;
  logic        out_valid_o, out_stall_i;
  logic        scheduled_o;
  logic [3:0]  placed_core_o;
  logic [15:0] placed_job_o;
  logic        queue_overflow_o;
  logic [63:0] wait_total_o, turnaround_total_o, response_total_o;
  logic [15:0] jobs_done_o;
  int          fails, pending;

  int          cyc = 0;
  logic        calm;
  int          hold_reqs = 0;
  logic [31:0] clock_now = '0;
  int          active_n = 1;
  int          sent = 0;

  multi_core_job_scheduler_unit i_dut (.*);
  mcjs_checker i_checker (.*);

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  assign calm = (cyc >= 30000 && cyc < 45000);

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int served;
    served = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_reqs > served) begin
        served++;
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= !calm && ($urandom_range(0, 99) < 6);
      end
    end
  end

  task automatic send_word(opcode_e op, logic [15:0] jid, logic [3:0] core,
                           logic [31:0] t, logic [31:0] run, logic [15:0] prio);
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    job_id_i       <= jid;
    core_index_i   <= core;
    event_time_i   <= t;
    run_time_i     <= run;
    job_priority_i <= prio;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    sent++;
    if (!calm && $urandom_range(0, 99) < 6) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic index, logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_mode(logic [2:0] sch, logic [4:0] cores);
    drain_results();
    write_reg(RegScheme, 32'(sch));
    write_reg(RegCores, 32'(cores));
    active_n = (cores == 0) ? 1 : ((cores > 16) ? 16 : cores);
  endtask

  task automatic random_job(int new_pct);
    int r;
    logic [31:0] run;
    logic [15:0] prio;
    logic [3:0]  core;
    logic [15:0] jid;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 2) clock_now = $urandom;
    else clock_now += $urandom_range(0, 20);
    run = ($urandom_range(0, 9) == 0) ? 32'd0 :
          (($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(1, 60));
    prio = ($urandom_range(0, 9) < 6) ? 16'($urandom_range(0, 7)) : 16'($urandom);
    core = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) :
           4'($urandom_range(0, active_n - 1));
    jid = 16'($urandom);
    if (r < new_pct) send_word(OP_NEW, jid, core, clock_now, run, prio);
    else if (r < new_pct + (100 - new_pct) * 55 / 100)
      send_word(OP_FINISH, jid, core, clock_now, run, prio);
    else if (r < 95) send_word(OP_QUANTUM, jid, core, clock_now, run, prio);
    else send_word(OP_QUERY, jid, core, clock_now, run, prio);
  endtask

  initial begin
    int phase;
    logic [4:0] cores_pick;
    rst_ni         <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    in_valid_i     <= 1'b0;
    opcode_i       <= OP_QUERY;
    job_id_i       <= '0;
    core_index_i   <= '0;
    event_time_i   <= '0;
    run_time_i     <= '0;
    job_priority_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(OP_QUERY, 16'h0, 4'h0, 32'd0, 32'd0, 16'h0);
    set_mode(SchPpri, 5'd2);
    send_word(OP_NEW, 16'h0000, 4'h0, 32'd0, 32'd0, 16'h0000);
    send_word(OP_NEW, 16'hFFFF, 4'h0, 32'd5, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(OP_NEW, 16'h0003, 4'h0, 32'd5, 32'd10, 16'h0005);
    send_word(OP_NEW, 16'h0004, 4'h0, 32'd6, 32'd10, 16'h0009);
    send_word(OP_QUANTUM, 16'h0, 4'h1, 32'd8, 32'd0, 16'h0);
    send_word(OP_FINISH, 16'h0, 4'h0, 32'd9, 32'd0, 16'h0);
    send_word(OP_FINISH, 16'h0, 4'hF, 32'd10, 32'd0, 16'h0);
    send_word(OP_QUANTUM, 16'h0, 4'hF, 32'd10, 32'd0, 16'h0);
    send_word(OP_FINISH, 16'h0, 4'h0, 32'd11, 32'd0, 16'h0);
    send_word(OP_FINISH, 16'h0, 4'h0, 32'd12, 32'd0, 16'h0);
    send_word(OP_FINISH, 16'h0, 4'h1, 32'd3, 32'd0, 16'h0);
    send_word(OP_FINISH, 16'h0, 4'h1, 32'd3, 32'd0, 16'h0);
    send_word(OP_QUANTUM, 16'h0, 4'h1, 32'd4, 32'd0, 16'h0);
    send_word(OP_NEW, 16'h1234, 4'h0, 32'hFFFF_FFFF, 32'd7, 16'h8000);
    send_word(OP_QUERY, 16'h0, 4'h0, 32'd0, 32'd0, 16'h0);
    set_mode(3'd7, 5'd0);
    send_word(OP_NEW, 16'h0055, 4'h0, 32'd1, 32'd3, 16'h0001);
    send_word(OP_QUANTUM, 16'h0, 4'h0, 32'd2, 32'd0, 16'h0);
    set_mode(SchRr, 5'd31);
    send_word(OP_NEW, 16'h00AA, 4'h0, 32'd2, 32'd3, 16'h0001);
    send_word(OP_FINISH, 16'h0, 4'hF, 32'd9, 32'd0, 16'h0);

    phase = 0;
    while (sent < ItemTarget) begin
      case ($urandom_range(0, 6))
        0: cores_pick = 5'd1;
        1: cores_pick = 5'd2;
        2: cores_pick = 5'd16;
        3: cores_pick = 5'($urandom_range(17, 31));
        4: cores_pick = 5'd0;
        default: cores_pick = 5'($urandom_range(1, 8));
      endcase
      if (phase == 3) begin
        set_mode(3'($urandom_range(0, 4)), 5'd1);
        repeat (90) random_job(100);
      end else begin
        set_mode(3'($urandom_range(0, 7)), cores_pick);
        if (phase == 6) hold_reqs++;
        repeat ($urandom_range(60, 150)) random_job($urandom_range(35, 60));
      end
      phase++;
    end

    drain_results();
    if (fails == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/mcjs_pkg.sv
hdl/mcjs_ctrl.sv
hdl/mcjs_dpath.sv
hdl/multi_core_job_scheduler_unit.sv
hdl/mcjs_checker.sv
tb/mcjs_checker.sv
tb/multi_core_job_scheduler_unit_test.sv
